// ----- rtl/e2pg_pkg.sv -----
// Shared constants, types and fixed-point helpers for the Euler-to-gravity pipeline.
package e2pg_pkg;

   // Three axes: roll, pitch, yaw
   localparam int AXES = 3;
   localparam int ROLL = 0;
   localparam int PITCH = 1;
   localparam int YAW = 2;

   // CORDIC rotation steps, one pipeline stage each
   localparam int CORDIC_STEPS = 24;

   // Widths: input angles, residual angle (Q.28), trig and product words (Q.30),
   // gravity accumulation before rounding
   localparam int IN_W = 16;
   localparam int ANGLE_W = 32;
   localparam int WORD_W = 33;
   localparam int G_W = 36;
   localparam int FRAC_W = 30;

   // Register stages from accepted beat to result strobe:
   // reduce, CORDIC steps, sign fix, pair product, triple product,
   // quaternion sum, quadratic product, round and saturate
   localparam int PIPE_DEPTH = CORDIC_STEPS + 7;

   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [G_W-1:0] grav_type;
   typedef logic signed [IN_W-1:0] sample_type;

   localparam word_type CORDIC_K = WORD_W'(652032875);
   localparam angle_type PI_Q28 = ANGLE_W'(843314857);
   localparam angle_type HALF_PI_Q28 = ANGLE_W'(421657428);
   localparam grav_type ONE_Q30 = G_W'(1073741824);
   localparam grav_type ROUND_HALF = G_W'(32768);
   localparam int OUT_SHIFT = 16;
   localparam grav_type OUT_MAX = G_W'(16384);
   localparam grav_type OUT_MIN = -G_W'(16384);

   // Arctangent of 2^-i in Q.28
   localparam angle_type ATAN_TABLE [CORDIC_STEPS] = '{
      ANGLE_W'(210828714), ANGLE_W'(124459457), ANGLE_W'(65760959), ANGLE_W'(33381290),
      ANGLE_W'(16755422), ANGLE_W'(8385879), ANGLE_W'(4193963), ANGLE_W'(2097109),
      ANGLE_W'(1048571), ANGLE_W'(524287), ANGLE_W'(262144), ANGLE_W'(131072),
      ANGLE_W'(65536), ANGLE_W'(32768), ANGLE_W'(16384), ANGLE_W'(8192),
      ANGLE_W'(4096), ANGLE_W'(2048), ANGLE_W'(1024), ANGLE_W'(512),
      ANGLE_W'(256), ANGLE_W'(128), ANGLE_W'(64), ANGLE_W'(32)
   };

   // Q.30 times Q.30, floor back to Q.30
   function automatic word_type qmul(input word_type a, input word_type b);
      logic signed [2*WORD_W-1:0] prod;
      prod = (2*WORD_W)'(a) * (2*WORD_W)'(b);
      return prod[WORD_W+FRAC_W-1:FRAC_W];
   endfunction

endpackage

// ----- rtl/euler_to_projected_gravity_core.sv -----
// Euler angles to body-frame projected gravity, fully pipelined.
//
// Takes one beat of roll, pitch and yaw (signed Q2.13 radians) in every clock cycle
// and returns the body-frame gravity vector (signed Q1.14, saturated to +/-1) at
// the end of the pipeline: rsp_strobe is high in the same cycle that the result is
// on the rsp_gravity ports. The depth comes from a reduction stage, the 24-step
// sine/cosine CORDIC, one rotation per stage, then a sign-fix stage and five
// multiply/round stages. busy is always low: the pipeline never holds off a beat,
// and each result shows on the rsp_ ports for exactly one cycle with no way to
// stall it, so the receiver must take every strobed beat.
module euler_to_projected_gravity_core
   import e2pg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic signed [15:0] req_roll_angle,
   input  logic signed [15:0] req_pitch_angle,
   input  logic signed [15:0] req_yaw_angle,
   output logic              rsp_strobe,
   output logic signed [15:0] rsp_gravity_x,
   output logic signed [15:0] rsp_gravity_y,
   output logic signed [15:0] rsp_gravity_z
);

   logic accept;
   sample_type raw_angle [AXES];

   // Valid bits travel alongside the data
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic [PIPE_DEPTH-1:0] vld_in;

   // CORDIC stage registers: index 0 holds the reduced angle
   angle_type ang_ff [CORDIC_STEPS+1][AXES];
   word_type  cx_ff  [CORDIC_STEPS+1][AXES];
   word_type  cy_ff  [CORDIC_STEPS+1][AXES];
   logic [AXES-1:0] flip_ff [CORDIC_STEPS+1];

   angle_type ang_in [AXES];
   logic [AXES-1:0] flip_in;

   // Sine and cosine after the sign fix
   word_type sin_ff [AXES];
   word_type cos_ff [AXES];

   // Pair products and delayed yaw terms
   word_type srcp_ff, crsp_ff, crcp_ff, srsp_ff, sy1_ff, cy1_ff;
   // Triple products
   word_type trip_ff [8];
   word_type trip_in [8];
   // Quaternion
   word_type qx_ff, qy_ff, qz_ff, qw_ff;
   // Quadratic products
   word_type wy_ff, zx_ff, zy_ff, wx_ff, ww_ff, zz_ff;
   // Result register
   logic signed [15:0] gx_ff, gy_ff, gz_ff;
   grav_type gx_sum, gy_sum, gz_sum;

   assign accept = start && !busy;
   assign busy = 1'b0;

   assign raw_angle[ROLL]  = req_roll_angle;
   assign raw_angle[PITCH] = req_pitch_angle;
   assign raw_angle[YAW]   = req_yaw_angle;

   // Advance the valid bits one stage per cycle
   always_comb begin
      vld_in = {vld_ff[PIPE_DEPTH-2:0], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Scale to half angle in Q.28 and fold beyond a quarter turn
   always_comb begin
      angle_type full;
      for (int a = 0; a < AXES; a++) begin
         full = ANGLE_W'(raw_angle[a]) <<< 14;
         if (full > HALF_PI_Q28) begin
            ang_in[a] = full - PI_Q28;
            flip_in[a] = 1'b1;
         end else if (full < -HALF_PI_Q28) begin
            ang_in[a] = full + PI_Q28;
            flip_in[a] = 1'b1;
         end else begin
            ang_in[a] = full;
            flip_in[a] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < AXES; a++) begin
         ang_ff[0][a] <= ang_in[a];
         cx_ff[0][a] <= CORDIC_K;
         cy_ff[0][a] <= '0;
      end
      flip_ff[0] <= flip_in;
   end

   // Rotate one CORDIC step per stage
   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
      for (genvar a = 0; a < AXES; a++) begin : g_axis
         word_type  dx_in, dy_in, cx_in, cy_in;
         angle_type step_in;

         assign dx_in = cy_ff[k][a] >>> k;
         assign dy_in = cx_ff[k][a] >>> k;

         always_comb begin
            if (ang_ff[k][a] >= 0) begin
               cx_in = cx_ff[k][a] - dx_in;
               cy_in = cy_ff[k][a] + dy_in;
               step_in = ang_ff[k][a] - ATAN_TABLE[k];
            end else begin
               cx_in = cx_ff[k][a] + dx_in;
               cy_in = cy_ff[k][a] - dy_in;
               step_in = ang_ff[k][a] + ATAN_TABLE[k];
            end
         end

         always_ff @(posedge clock) begin
            cx_ff[k+1][a] <= cx_in;
            cy_ff[k+1][a] <= cy_in;
            ang_ff[k+1][a] <= step_in;
         end
      end

      always_ff @(posedge clock) begin
         flip_ff[k+1] <= flip_ff[k];
      end
   end

   // Negate sine and cosine of folded angles
   always_ff @(posedge clock) begin
      for (int a = 0; a < AXES; a++) begin
         sin_ff[a] <= flip_ff[CORDIC_STEPS][a] ? -cy_ff[CORDIC_STEPS][a]
                                               : cy_ff[CORDIC_STEPS][a];
         cos_ff[a] <= flip_ff[CORDIC_STEPS][a] ? -cx_ff[CORDIC_STEPS][a]
                                               : cx_ff[CORDIC_STEPS][a];
      end
   end

   // Roll-pitch pair products; hold yaw terms alongside
   always_ff @(posedge clock) begin
      srcp_ff <= qmul(sin_ff[ROLL], cos_ff[PITCH]);
      crsp_ff <= qmul(cos_ff[ROLL], sin_ff[PITCH]);
      crcp_ff <= qmul(cos_ff[ROLL], cos_ff[PITCH]);
      srsp_ff <= qmul(sin_ff[ROLL], sin_ff[PITCH]);
      sy1_ff <= sin_ff[YAW];
      cy1_ff <= cos_ff[YAW];
   end

   // Triple products with yaw
   always_comb begin
      trip_in[0] = qmul(srcp_ff, cy1_ff);
      trip_in[1] = qmul(crsp_ff, sy1_ff);
      trip_in[2] = qmul(crsp_ff, cy1_ff);
      trip_in[3] = qmul(srcp_ff, sy1_ff);
      trip_in[4] = qmul(crcp_ff, sy1_ff);
      trip_in[5] = qmul(srsp_ff, cy1_ff);
      trip_in[6] = qmul(crcp_ff, cy1_ff);
      trip_in[7] = qmul(srsp_ff, sy1_ff);
   end

   always_ff @(posedge clock) begin
      trip_ff <= trip_in;
   end

   // Form the quaternion
   always_ff @(posedge clock) begin
      qx_ff <= trip_ff[0] - trip_ff[1];
      qy_ff <= trip_ff[2] + trip_ff[3];
      qz_ff <= trip_ff[4] - trip_ff[5];
      qw_ff <= trip_ff[6] + trip_ff[7];
   end

   // Quadratic terms of the gravity projection
   always_ff @(posedge clock) begin
      wy_ff <= qmul(qw_ff, qy_ff);
      zx_ff <= qmul(qz_ff, qx_ff);
      zy_ff <= qmul(qz_ff, qy_ff);
      wx_ff <= qmul(qw_ff, qx_ff);
      ww_ff <= qmul(qw_ff, qw_ff);
      zz_ff <= qmul(qz_ff, qz_ff);
   end

   // Round Q.30 to Q1.14 half up and clamp to plus or minus one
   function automatic logic signed [15:0] round_sat(input grav_type v);
      grav_type r;
      r = (v + ROUND_HALF) >>> OUT_SHIFT;
      if (r > OUT_MAX) begin
         r = OUT_MAX;
      end else if (r < OUT_MIN) begin
         r = OUT_MIN;
      end
      return r[15:0];
   endfunction

   always_comb begin
      gx_sum = (G_W'(wy_ff) - G_W'(zx_ff)) <<< 1;
      gy_sum = -((G_W'(zy_ff) + G_W'(wx_ff)) <<< 1);
      gz_sum = ONE_Q30 - ((G_W'(ww_ff) + G_W'(zz_ff)) <<< 1);
   end

   always_ff @(posedge clock) begin
      gx_ff <= round_sat(gx_sum);
      gy_ff <= round_sat(gy_sum);
      gz_ff <= round_sat(gz_sum);
   end

   assign rsp_strobe = vld_ff[PIPE_DEPTH-1];
   assign rsp_gravity_x = gx_ff;
   assign rsp_gravity_y = gy_ff;
   assign rsp_gravity_z = gz_ff;

   // A result beat only ever comes from an accepted beat that has run the full pipeline
   a_strobe_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, PIPE_DEPTH))
      else $error("result strobe without matching accepted beat");

   // An accepted beat with no reset in between reaches the output
   a_accept_reaches_out: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[0] && !$past(reset)) |=> ##(PIPE_DEPTH-2) rsp_strobe)
      else $error("accepted beat dropped in pipeline");

   // Strobed gravity components stay within plus or minus one
   a_out_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_gravity_x <= 16'sd16384 && rsp_gravity_x >= -16'sd16384 &&
                      rsp_gravity_y <= 16'sd16384 && rsp_gravity_y >= -16'sd16384 &&
                      rsp_gravity_z <= 16'sd16384 && rsp_gravity_z >= -16'sd16384))
      else $error("gravity component out of range");

endmodule

// ----- tb/euler_to_projected_gravity_core_tb.sv -----
// Self-checking testbench for the Euler-angle to projected-gravity pipeline.
`timescale 1ns / 1ps

module euler_to_projected_gravity_core_tb
   import e2pg_pkg::*;
;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_BEATS = 1900;
   localparam int MAX_REPORTS = 10;

   // Q.28 half angle beyond which the sine/cosine are folded back by pi
   localparam longint QUARTER_TURN_Q28 = 64'sd421657428;
   localparam longint HALF_TURN_Q28 = 64'sd843314857;
   localparam longint GAIN_Q30 = 64'sd652032875;
   localparam longint UNIT_Q30 = 64'sd1073741824;
   localparam longint GRAVITY_LIMIT = 64'sd16384;
   localparam int TRIG_STEPS = 24;
   localparam int ANGLE_IN_RANGE = 25736;

   localparam longint ARCTAN_Q28 [TRIG_STEPS] = '{
      64'sd210828714, 64'sd124459457, 64'sd65760959, 64'sd33381290,
      64'sd16755422, 64'sd8385879, 64'sd4193963, 64'sd2097109,
      64'sd1048571, 64'sd524287, 64'sd262144, 64'sd131072,
      64'sd65536, 64'sd32768, 64'sd16384, 64'sd8192,
      64'sd4096, 64'sd2048, 64'sd1024, 64'sd512,
      64'sd256, 64'sd128, 64'sd64, 64'sd32
   };

   typedef struct {
      sample_type x;
      sample_type y;
      sample_type z;
   } gravity_type;

   typedef struct {
      sample_type  roll;
      sample_type  pitch;
      sample_type  yaw;
      bit          typed;
      gravity_type gravity;
   } attitude_row_type;

   localparam int ROW_COUNT = 22;

   // Level attitude reads straight off as gravity pointing down the body z axis
   attitude_row_type attitude_rows [ROW_COUNT] = '{
      '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 16'sd0, -16'sd16384}},
      '{16'sd25736, 16'sd0, 16'sd0, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
      '{-16'sd25736, 16'sd0, 16'sd0, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
      '{16'sd0, 16'sd25736, 16'sd0, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
      '{16'sd0, -16'sd25736, 16'sd0, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
      '{16'sd0, 16'sd0, 16'sd25736, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
      '{16'sd0, 16'sd0, -16'sd25736, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
      '{16'sd25737, 16'sd25737, 16'sd25737, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
      '{-16'sd25737, -16'sd25737, -16'sd25737, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
      '{16'sd32767, 16'sd0, 16'sd0, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
      '{16'sh8000, 16'sd0, 16'sd0, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
      '{16'sd0, 16'sd32767, 16'sh8000, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
      '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
      '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
      '{16'sd12868, 16'sd12868, 16'sd12868, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
      '{-16'sd12868, 16'sd12868, -16'sd12868, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
      '{16'sd1, -16'sd1, 16'sd1, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
      '{16'sh5555, 16'shAAAA, 16'sh5555, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
      '{16'shAAAA, 16'sh5555, 16'shAAAA, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
      '{16'sd25736, 16'sd25736, 16'sd25736, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
      '{-16'sd25736, 16'sd25737, -16'sd25737, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
      '{16'sd8192, -16'sd4096, 16'sd20000, 1'b0, '{16'sd0, 16'sd0, 16'sd0}}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   sample_type req_roll_angle = '0;
   sample_type req_pitch_angle = '0;
   sample_type req_yaw_angle = '0;
   logic       busy;
   logic       rsp_strobe;
   sample_type rsp_gravity_x;
   sample_type rsp_gravity_y;
   sample_type rsp_gravity_z;

   gravity_type gravity_due [$];
   int       mismatches = 0;
   int       beats_sent = 0;
   int       results_seen = 0;
   int       folded_beats = 0;
   int       sender_idle_pct = 0;
   int       cycle_count = 0;

   euler_to_projected_gravity_core dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_roll_angle (req_roll_angle),
      .req_pitch_angle(req_pitch_angle),
      .req_yaw_angle  (req_yaw_angle),
      .rsp_strobe     (rsp_strobe),
      .rsp_gravity_x  (rsp_gravity_x),
      .rsp_gravity_y  (rsp_gravity_y),
      .rsp_gravity_z  (rsp_gravity_z)
   );

   always #10 clock = ~clock;

   // Q.30 product, floor back to Q.30
   function automatic longint q30_mul(input longint a, input longint b);
      return (a * b) >>> 30;
   endfunction

   // Rotation-mode CORDIC on the half angle, folded into +/- a quarter turn
   function automatic void half_angle_trig(input sample_type raw, output longint sine,
                                           output longint cosine);
      longint ang;
      longint vx;
      longint vy;
      longint dx;
      longint dy;
      bit     fold;
      ang = longint'(raw) * 16384;
      vx = GAIN_Q30;
      vy = 0;
      fold = 1'b0;
      if (ang > QUARTER_TURN_Q28) begin
         ang -= HALF_TURN_Q28;
         fold = 1'b1;
      end else if (ang < -QUARTER_TURN_Q28) begin
         ang += HALF_TURN_Q28;
         fold = 1'b1;
      end
      for (int i = 0; i < TRIG_STEPS; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (ang >= 0) begin
            vx -= dx;
            vy += dy;
            ang -= ARCTAN_Q28[i];
         end else begin
            vx += dx;
            vy -= dy;
            ang += ARCTAN_Q28[i];
         end
      end
      sine = fold ? -vy : vy;
      cosine = fold ? -vx : vx;
   endfunction

   // Round half up to Q1.14 and clamp to +/- one
   function automatic sample_type gravity_word(input longint v);
      longint r;
      r = (v + 64'sd32768) >>> 16;
      if (r > GRAVITY_LIMIT) r = GRAVITY_LIMIT;
      if (r < -GRAVITY_LIMIT) r = -GRAVITY_LIMIT;
      return sample_type'(r);
   endfunction

   function automatic gravity_type predict_gravity(input sample_type roll,
                                                   input sample_type pitch,
                                                   input sample_type yaw);
      longint sr, cr, sp, cp, sy, cy;
      longint qx, qy, qz, qw;
      gravity_type g;
      half_angle_trig(roll, sr, cr);
      half_angle_trig(pitch, sp, cp);
      half_angle_trig(yaw, sy, cy);
      qx = q30_mul(q30_mul(sr, cp), cy) - q30_mul(q30_mul(cr, sp), sy);
      qy = q30_mul(q30_mul(cr, sp), cy) + q30_mul(q30_mul(sr, cp), sy);
      qz = q30_mul(q30_mul(cr, cp), sy) - q30_mul(q30_mul(sr, sp), cy);
      qw = q30_mul(q30_mul(cr, cp), cy) + q30_mul(q30_mul(sr, sp), sy);
      g.x = gravity_word(2 * (q30_mul(qw, qy) - q30_mul(qz, qx)));
      g.y = gravity_word(-2 * (q30_mul(qz, qy) + q30_mul(qw, qx)));
      g.z = gravity_word(UNIT_Q30 - 2 * (q30_mul(qw, qw) + q30_mul(qz, qz)));
      return g;
   endfunction

   // True when the half angle lands past a quarter turn and gets folded
   function automatic bit beyond_quarter(input sample_type raw);
      longint ang;
      ang = longint'(raw) * 16384;
      return (ang > QUARTER_TURN_Q28) || (ang < -QUARTER_TURN_Q28);
   endfunction

   // Mostly legal angles, a good share of raw 16-bit words, plus fold edges and extremes
   function automatic sample_type random_angle();
      int pick;
      pick = $urandom_range(9);
      case (pick)
         0, 1, 2: return sample_type'($urandom);
         3, 4, 5, 6: return sample_type'($urandom_range(2 * ANGLE_IN_RANGE) - ANGLE_IN_RANGE);
         7: return sample_type'(($urandom_range(1) ? 1 : -1)
                                * (ANGLE_IN_RANGE - 3 + int'($urandom_range(6))));
         8: begin
            case ($urandom_range(4))
               0: return 16'sd32767;
               1: return 16'sh8000;
               2: return 16'sd1;
               3: return -16'sd1;
               default: return 16'sd0;
            endcase
         end
         default: return sample_type'(int'($urandom_range(64)) - 32);
      endcase
   endfunction

   task automatic flag_mismatch(input string what, input sample_type want, input sample_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   // Present one beat, hold it until accepted, then queue its gravity
   task automatic send_attitude(input sample_type roll, input sample_type pitch,
                                input sample_type yaw, input bit typed,
                                input gravity_type typed_g);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_roll_angle <= roll;
      req_pitch_angle <= pitch;
      req_yaw_angle <= yaw;
      @(posedge clock);
      while (busy) @(posedge clock);
      gravity_due.push_back(typed ? typed_g : predict_gravity(roll, pitch, yaw));
      beats_sent++;
      if (beyond_quarter(roll) || beyond_quarter(pitch) || beyond_quarter(yaw))
         folded_beats++;
   endtask

   // Compare each strobed result against the oldest pending gravity
   always @(posedge clock) begin : check_results
      gravity_type want;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (gravity_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result strobed with no beat pending", $realtime);
         end else begin
            want = gravity_due.pop_front();
            if (rsp_gravity_x !== want.x) flag_mismatch("gravity_x", want.x, rsp_gravity_x);
            if (rsp_gravity_y !== want.y) flag_mismatch("gravity_y", want.y, rsp_gravity_y);
            if (rsp_gravity_z !== want.z) flag_mismatch("gravity_z", want.z, rsp_gravity_z);
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results pending",
                  cycle_count, gravity_due.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      gravity_type none;
      none = '{16'sd0, 16'sd0, 16'sd0};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed rows back to back
      foreach (attitude_rows[i])
         send_attitude(attitude_rows[i].roll, attitude_rows[i].pitch, attitude_rows[i].yaw,
                       attitude_rows[i].typed, attitude_rows[i].gravity);

      // Random beats: light sender gaps, heavy gaps, then full rate
      sender_idle_pct = 21;
      repeat (RANDOM_BEATS / 3)
         send_attitude(random_angle(), random_angle(), random_angle(), 1'b0, none);
      sender_idle_pct = 67;
      repeat (RANDOM_BEATS / 3)
         send_attitude(random_angle(), random_angle(), random_angle(), 1'b0, none);
      sender_idle_pct = 0;
      repeat (RANDOM_BEATS - 2 * (RANDOM_BEATS / 3))
         send_attitude(random_angle(), random_angle(), random_angle(), 1'b0, none);
      start <= 1'b0;

      // Drain, then watch for stray strobes
      while (gravity_due.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 8) @(posedge clock);

      $display("Sent %0d attitude beats (%0d with a half angle past a quarter turn),",
               beats_sent, folded_beats);
      $display("checked %0d gravity results, %0d mismatches", results_seen, mismatches);
      if (mismatches == 0 && gravity_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/e2pg_pkg.sv
rtl/euler_to_projected_gravity_core.sv
tb/euler_to_projected_gravity_core_tb.sv
